>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the attitude estimator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define IAC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define IAC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> src/iac_pkg.sv
// ----------------------------------------------------------------------------
// iac_pkg
// Types, constants and helper functions of the IMU attitude estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package iac_pkg;

    localparam int CAL_SAMPLES  = 100;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int CAL_W        = $clog2(CAL_SAMPLES + 1);

    // floor(x / CAL_SAMPLES) == (x * DIV_MULT) >> 32 for x < 2^24
    localparam logic [32:0] DIV_MULT =
        33'(((64'd1 << 32) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    localparam logic signed [25:0] ANG_MAX  = 26'sh1FFFFFF;
    localparam logic signed [25:0] ANG_MIN  = 26'sh2000000;
    localparam logic signed [25:0] DEG180   = 26'sd11796480;
    localparam logic [29:0]        INV_GAIN = 30'd652032874;

    localparam logic [16:0] W_ONE       = 17'd65536;
    localparam logic [16:0] W_RESET     = 17'd64225;
    localparam logic [23:0] SCALE_RESET = 24'd128070;

    localparam logic CFG_WEIGHT = 1'b0;
    localparam logic CFG_SCALE  = 1'b1;

    typedef enum logic [1:0] {PH_CAL, PH_RUN, PH_FAIL} t_phase;

    typedef enum logic [1:0] {
        K_RESTART_OK, K_RESTART_FAIL, K_SAMPLE_OK, K_SAMPLE_FAIL
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_BIAS_MUL, S_BIAS_SET, S_GMUL1, S_GMUL2, S_GRND,
        S_CR_START, S_CR_WAIT, S_MAG, S_CP_WAIT, S_BL1, S_BL2, S_BL3,
        S_YAW, S_OUT
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [19:0]        step_time;
    } t_item;

    typedef struct packed {
        logic  avail;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic               start;
        logic signed [32:0] x;
        logic signed [32:0] y;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [25:0] ang;
        logic [30:0]        mag_raw;
    } t_cordic_rsp;

    typedef struct packed {
        logic signed [25:0] roll_angle;
        logic signed [25:0] pitch_angle;
        logic signed [25:0] yaw_angle;
        logic               attitude_valid;
        logic               calibrating;
    } t_result;

    // atan(2^-i) in Q.16 degrees
    function automatic logic signed [25:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [25:0] v;
        unique case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [25:0] sat26(input logic signed [39:0] v);
        logic signed [25:0] r;
        if (v > 40'(ANG_MAX)) begin
            r = ANG_MAX;
        end else if (v < 40'(ANG_MIN)) begin
            r = ANG_MIN;
        end else begin
            r = v[25:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/iac_front.sv
// ----------------------------------------------------------------------------
// iac_front
// Input side: takes stream transfers, tags each item by kind and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tvalid,
    output logic                 o_tready,
    input  wire logic [1:0]      i_tuser,
    input  wire logic [119:0]    i_tdata,
    output iac_pkg::t_q_head     o_head,
    input  wire logic            i_pop
);

    iac_pkg::t_item r_q [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    iac_pkg::t_item in_item;
    logic           push;

    always_comb begin
        priority if (i_tuser[0]) begin
            in_item.kind = i_tuser[1] ? iac_pkg::K_RESTART_OK : iac_pkg::K_RESTART_FAIL;
        end else begin
            in_item.kind = i_tuser[1] ? iac_pkg::K_SAMPLE_OK : iac_pkg::K_SAMPLE_FAIL;
        end
        in_item.accel_x   = i_tdata[15:0];
        in_item.accel_y   = i_tdata[31:16];
        in_item.accel_z   = i_tdata[47:32];
        in_item.gyro_x    = i_tdata[63:48];
        in_item.gyro_y    = i_tdata[79:64];
        in_item.gyro_z    = i_tdata[95:80];
        in_item.step_time = i_tdata[115:96];
    end

    assign o_tready     = (r_count != 2'd2);
    assign push         = i_tvalid && o_tready;
    assign o_head.avail = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

>>> src/iac_cordic.sv
// ----------------------------------------------------------------------------
// iac_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle and raw
// (gain-scaled) magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_cordic (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  iac_pkg::t_cordic_req  i_req,
    output iac_pkg::t_cordic_rsp  o_rsp
);

    logic                       r_busy, r_done, r_zero;
    logic [iac_pkg::STEP_W-1:0] r_cnt;
    logic signed [32:0]         r_x, r_y;
    logic signed [25:0]         r_z;

    logic signed [32:0] x0, y0, xs, ys, n_x, n_y;
    logic signed [25:0] z0, n_z;

    always_comb begin
        // left half plane: turn by 180 degrees first
        if (i_req.x < 0) begin
            x0 = -i_req.x;
            y0 = -i_req.y;
            z0 = (i_req.y >= 0) ? iac_pkg::DEG180 : -iac_pkg::DEG180;
        end else begin
            x0 = i_req.x;
            y0 = i_req.y;
            z0 = 26'sd0;
        end
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        if (r_y >= 0) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + iac_pkg::atan_entry(r_cnt);
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - iac_pkg::atan_entry(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= x0;
            r_y    <= y0;
            r_z    <= z0;
            r_zero <= (i_req.x == 0) && (i_req.y == 0);
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == iac_pkg::STEP_W'(iac_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.ang     = r_zero ? 26'sd0 : r_z;
    assign o_rsp.mag_raw = r_x[30:0];

endmodule

`default_nettype wire

>>> src/iac_core.sv
// ----------------------------------------------------------------------------
// iac_core
// Back end: calibration, gyro integration, accel angles and the blend, run
// by a sequencer around one CORDIC unit and stepwise multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  iac_pkg::t_q_head   i_head,
    output logic               o_pop,
    input  wire logic [16:0]   i_weight,
    input  wire logic [23:0]   i_scale,
    input  wire logic          i_res_ready,
    output logic               o_res_load,
    output iac_pkg::t_result   o_res
);

    iac_pkg::t_bstate           r_state, n_state;
    iac_pkg::t_phase            r_phase, n_phase;
    logic                       r_valid, n_valid;
    logic [iac_pkg::CAL_W-1:0]  r_cnt, n_cnt;
    logic signed [23:0]         r_sum [3];
    logic signed [23:0]         n_sum [3];
    logic signed [15:0]         r_bias [3];
    logic signed [15:0]         n_bias [3];
    logic signed [34:0]         r_inc [3];
    logic signed [34:0]         n_inc [3];
    logic signed [25:0]         r_roll, n_roll, r_pitch, n_pitch, r_yaw, n_yaw;
    logic signed [25:0]         r_ar, n_ar;
    iac_pkg::t_item             r_item, n_item;
    logic [1:0]                 r_k, n_k;
    logic [56:0]                r_bprod, n_bprod;
    logic signed [41:0]         r_p1, n_p1;
    logic signed [62:0]         r_p2, n_p2;
    logic [60:0]                r_mprod, n_mprod;
    logic signed [53:0]         r_t1, n_t1;
    logic signed [43:0]         r_t2, n_t2;

    iac_pkg::t_cordic_req cr_req;
    iac_pkg::t_cordic_rsp cr_rsp;

    logic               cal_done;
    logic [23:0]        sum_mag;
    logic [24:0]        quo;
    logic signed [15:0] gyro_k;
    logic signed [16:0] diff;
    logic [62:0]        p2_mag;
    logic [34:0]        inc_mag;
    logic [16:0]        w, w_c;
    logic signed [35:0] est_sum;
    logic signed [54:0] blend;
    logic [54:0]        blend_mag;
    logic [38:0]        blend_rnd;
    logic signed [39:0] blend_res;
    logic signed [36:0] yaw_sum;
    logic [30:0]        mag_m;

    iac_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cr_req),
        .o_rsp   (cr_rsp)
    );

    always_comb begin
        cal_done = (r_cnt + 1'b1) >= iac_pkg::CAL_W'(iac_pkg::CAL_SAMPLES);
        w        = (i_weight > iac_pkg::W_ONE) ? iac_pkg::W_ONE : i_weight;
        w_c      = iac_pkg::W_ONE - w;
        unique case (r_k)
            2'd0:    gyro_k = r_item.gyro_x;
            2'd1:    gyro_k = r_item.gyro_y;
            default: gyro_k = r_item.gyro_z;
        endcase
        sum_mag   = r_sum[r_k][23] ? 24'(-r_sum[r_k]) : 24'(r_sum[r_k]);
        quo       = r_bprod[56:32];
        diff      = 17'(gyro_k) - 17'(r_bias[r_k]);
        p2_mag    = r_p2[62] ? 63'(-r_p2) : 63'(r_p2);
        inc_mag   = 35'((p2_mag + (63'd1 << 27)) >> 28);
        est_sum   = (r_k == 2'd0) ? 36'(r_roll) + 36'(r_inc[0])
                                  : 36'(r_pitch) + 36'(r_inc[1]);
        blend     = 55'(r_t1) + 55'(r_t2);
        blend_mag = blend[54] ? 55'(-blend) : 55'(blend);
        blend_rnd = 39'((blend_mag + (55'd1 << 15)) >> 16);
        blend_res = blend[54] ? -40'(blend_rnd) : 40'(blend_rnd);
        yaw_sum   = 37'(r_yaw) + 37'(r_inc[2]);
        if (yaw_sum > 37'(iac_pkg::DEG180)) begin
            yaw_sum = yaw_sum - 37'(iac_pkg::DEG180) - 37'(iac_pkg::DEG180);
        end
        if (yaw_sum < -37'(iac_pkg::DEG180)) begin
            yaw_sum = yaw_sum + 37'(iac_pkg::DEG180) + 37'(iac_pkg::DEG180);
        end
        mag_m = 31'((r_mprod + (61'd1 << 29)) >> 30);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iac_pkg::S_IDLE: begin
                if (i_head.avail) begin
                    n_state = iac_pkg::S_OUT;
                    if (i_head.item.kind == iac_pkg::K_SAMPLE_OK) begin
                        if (r_phase == iac_pkg::PH_CAL && cal_done) begin
                            n_state = iac_pkg::S_BIAS_MUL;
                        end else if (r_phase == iac_pkg::PH_RUN && r_valid) begin
                            n_state = iac_pkg::S_GMUL1;
                        end
                    end
                end
            end
            iac_pkg::S_BIAS_MUL: n_state = iac_pkg::S_BIAS_SET;
            iac_pkg::S_BIAS_SET: n_state = (r_k == 2'd2) ? iac_pkg::S_CR_START
                                                         : iac_pkg::S_BIAS_MUL;
            iac_pkg::S_GMUL1:    n_state = iac_pkg::S_GMUL2;
            iac_pkg::S_GMUL2:    n_state = iac_pkg::S_GRND;
            iac_pkg::S_GRND:     n_state = (r_k == 2'd2) ? iac_pkg::S_CR_START
                                                         : iac_pkg::S_GMUL1;
            iac_pkg::S_CR_START: n_state = iac_pkg::S_CR_WAIT;
            iac_pkg::S_CR_WAIT:  if (cr_rsp.done) n_state = iac_pkg::S_MAG;
            iac_pkg::S_MAG:      n_state = iac_pkg::S_CP_WAIT;
            iac_pkg::S_CP_WAIT: begin
                if (cr_rsp.done) begin
                    n_state = (r_phase == iac_pkg::PH_CAL) ? iac_pkg::S_OUT
                                                           : iac_pkg::S_BL1;
                end
            end
            iac_pkg::S_BL1:      n_state = iac_pkg::S_BL2;
            iac_pkg::S_BL2:      n_state = iac_pkg::S_BL3;
            iac_pkg::S_BL3:      n_state = (r_k == 2'd1) ? iac_pkg::S_YAW
                                                         : iac_pkg::S_BL1;
            iac_pkg::S_YAW:      n_state = iac_pkg::S_OUT;
            iac_pkg::S_OUT:      if (i_res_ready) n_state = iac_pkg::S_IDLE;
            default:             n_state = iac_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase = r_phase;
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_bias  = r_bias;
        n_inc   = r_inc;
        n_roll  = r_roll;
        n_pitch = r_pitch;
        n_yaw   = r_yaw;
        n_ar    = r_ar;
        n_item  = r_item;
        n_k     = r_k;
        n_bprod = r_bprod;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_mprod = r_mprod;
        n_t1    = r_t1;
        n_t2    = r_t2;
        o_pop      = 1'b0;
        o_res_load = 1'b0;
        cr_req.start = 1'b0;
        cr_req.x     = 33'(r_item.accel_z) <<< 14;
        cr_req.y     = 33'(r_item.accel_y) <<< 14;

        unique case (r_state)
            iac_pkg::S_IDLE: begin
                if (i_head.avail) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    n_k    = 2'd0;
                    unique case (i_head.item.kind)
                        iac_pkg::K_RESTART_OK, iac_pkg::K_RESTART_FAIL: begin
                            n_roll  = '0;
                            n_pitch = '0;
                            n_yaw   = '0;
                            n_valid = 1'b0;
                            n_cnt   = '0;
                            for (int i = 0; i < 3; i++) n_sum[i] = '0;
                            n_phase = (i_head.item.kind == iac_pkg::K_RESTART_OK)
                                      ? iac_pkg::PH_CAL : iac_pkg::PH_FAIL;
                        end
                        iac_pkg::K_SAMPLE_FAIL: begin
                            if (r_phase != iac_pkg::PH_FAIL) begin
                                n_phase = iac_pkg::PH_FAIL;
                                n_valid = 1'b0;
                            end
                        end
                        default: begin
                            if (r_phase == iac_pkg::PH_CAL) begin
                                n_sum[0] = r_sum[0] + 24'(i_head.item.gyro_x);
                                n_sum[1] = r_sum[1] + 24'(i_head.item.gyro_y);
                                n_sum[2] = r_sum[2] + 24'(i_head.item.gyro_z);
                                n_cnt    = r_cnt + 1'b1;
                            end else if (r_phase == iac_pkg::PH_RUN && !r_valid) begin
                                n_phase = iac_pkg::PH_FAIL;
                            end
                        end
                    endcase
                end
            end
            iac_pkg::S_BIAS_MUL: begin
                n_bprod = 57'(sum_mag) * 57'(iac_pkg::DIV_MULT);
            end
            iac_pkg::S_BIAS_SET: begin
                n_bias[r_k] = r_sum[r_k][23] ? -quo[15:0] : quo[15:0];
                n_k = r_k + 1'b1;
            end
            iac_pkg::S_GMUL1: begin
                n_p1 = diff * $signed({1'b0, i_scale});
            end
            iac_pkg::S_GMUL2: begin
                n_p2 = r_p1 * $signed({1'b0, r_item.step_time});
            end
            iac_pkg::S_GRND: begin
                n_inc[r_k] = r_p2[62] ? -inc_mag : inc_mag;
                n_k = r_k + 1'b1;
            end
            iac_pkg::S_CR_START: begin
                cr_req.start = 1'b1;
            end
            iac_pkg::S_CR_WAIT: begin
                if (cr_rsp.done) begin
                    n_ar    = cr_rsp.ang;
                    n_mprod = 61'(cr_rsp.mag_raw) * 61'(iac_pkg::INV_GAIN);
                end
            end
            iac_pkg::S_MAG: begin
                cr_req.start = 1'b1;
                cr_req.x     = $signed({2'b00, mag_m});
                cr_req.y     = -(33'(r_item.accel_x) <<< 14);
            end
            iac_pkg::S_CP_WAIT: begin
                if (cr_rsp.done) begin
                    n_k = 2'd0;
                    if (r_phase == iac_pkg::PH_CAL) begin
                        n_roll  = r_ar;
                        n_pitch = cr_rsp.ang;
                        n_valid = 1'b1;
                        n_phase = iac_pkg::PH_RUN;
                    end else begin
                        // accel pitch angle waits in r_mprod for the blend
                        n_mprod = 61'($unsigned(cr_rsp.ang));
                    end
                end
            end
            iac_pkg::S_BL1: begin
                n_t1 = $signed({1'b0, w}) * est_sum;
            end
            iac_pkg::S_BL2: begin
                n_t2 = $signed({1'b0, w_c}) *
                       ((r_k == 2'd0) ? r_ar : $signed(r_mprod[25:0]));
            end
            iac_pkg::S_BL3: begin
                if (r_k == 2'd0) begin
                    n_roll = iac_pkg::sat26(blend_res);
                end else begin
                    n_pitch = iac_pkg::sat26(blend_res);
                end
                n_k = r_k + 1'b1;
            end
            iac_pkg::S_YAW: begin
                n_yaw = iac_pkg::sat26(40'(yaw_sum));
            end
            iac_pkg::S_OUT: begin
                o_res_load = i_res_ready;
            end
            default: ;
        endcase

        o_res.roll_angle     = r_roll;
        o_res.pitch_angle    = r_pitch;
        o_res.yaw_angle      = r_yaw;
        o_res.attitude_valid = r_valid;
        o_res.calibrating    = (r_phase == iac_pkg::PH_CAL);
    end

    always_ff @(posedge i_clk) begin
        r_inc   <= n_inc;
        r_ar    <= n_ar;
        r_item  <= n_item;
        r_k     <= n_k;
        r_bprod <= n_bprod;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_mprod <= n_mprod;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '{default: '0};
            r_bias  <= '{default: '0};
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else begin
            r_sum   <= n_sum;
            r_bias  <= n_bias;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iac_pkg::S_IDLE;
            r_phase <= iac_pkg::PH_CAL;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> src/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// Complementary-filter attitude estimator for raw six-axis IMU samples.
// The core takes one item at a time and pops the next only after the result
//   of the last is loaded into the output register, so output stalls hold it;
//   restart, failed and calibrating samples go straight to the output, while
//   a last calibration or running sample makes two CORDIC passes of 16 steps.
// Reset: synchronous active low; estimates clear, calibration phase, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_attitude (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] gyro_x,
    // [79:64] gyro_y, [95:80] gyro_z, [115:96] step_time, [119:116] zero
    input  wire logic [119:0] i_s_axis_tdata,
    // [0] mode, [1] sample_ok
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [25:0] roll_angle, [51:26] pitch_angle, [77:52] yaw_angle,
    // [78] attitude_valid, [79] calibrating
    output logic [79:0]       o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data
);

    iac_pkg::t_q_head  head;
    iac_pkg::t_result  res;
    logic              pop, res_load, res_ready;
    logic [16:0]       r_weight;
    logic [23:0]       r_scale;
    logic              r_out_valid;
    logic [79:0]       r_out_data;

    iac_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tuser  (i_s_axis_tuser),
        .i_tdata  (i_s_axis_tdata),
        .o_head   (head),
        .i_pop    (pop)
    );

    iac_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_weight    (r_weight),
        .i_scale     (r_scale),
        .i_res_ready (res_ready),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= iac_pkg::W_RESET;
            r_scale  <= iac_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iac_pkg::CFG_WEIGHT: r_weight <= i_cfg_data[16:0];
                iac_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= {res.calibrating, res.attitude_valid, res.yaw_angle,
                           res.pitch_angle, res.roll_angle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> src/iac_checker.sv
// ----------------------------------------------------------------------------
// iac_checker
// Port-level checks of the attitude estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iac_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [119:0] i_s_axis_tdata,
    input wire logic [1:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [79:0]  o_m_axis_tdata
);

    logic         out_stall, in_stall;
    logic [121:0] in_word;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign in_stall  = i_s_axis_tvalid && !o_s_axis_tready;
    assign in_word   = {i_s_axis_tuser, i_s_axis_tdata};

    `IAC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_m_axis_tvalid)
    `IAC_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(o_m_axis_tdata))
    `IAC_ASSERT(a_in_hold, i_clk, i_rst_n, in_stall |=> i_s_axis_tvalid && $stable(in_word))
    `IAC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    // an estimate is never marked valid while the bias is still being gathered
    `IAC_ASSERT(a_valid_not_cal, i_clk, i_rst_n, o_m_axis_tvalid |-> !(&o_m_axis_tdata[79:78]))

endmodule

bind imu_complementary_attitude iac_checker u_iac_checker (.*);

`default_nettype wire
